FILE: hdl/dmcts_pkg.sv
package dmcts_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int STALL_W = 8;
    localparam int CNT_W   = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [STALL_W-1:0] stall_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // access commands, the unused code acts as a store
    localparam cmd_t CMD_FETCH = 2'd0;
    localparam cmd_t CMD_LOAD  = 2'd1;
    localparam cmd_t CMD_STORE = 2'd2;

    // register indexes
    localparam logic REG_READ_MISS_PENALTY = 1'b0;
    localparam logic REG_WRITE_PENALTY     = 1'b1;

    localparam stall_t PENALTY_RESET = 8'd12;
    localparam cnt_t   CNT_MAX       = '1;
    localparam cnt_t   REFS_ON_FILL  = 32'd2;

    // saturating increment
    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // saturating add of a stall figure
    function automatic cnt_t sat_add(input cnt_t a, input stall_t b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W + 1 - STALL_W){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

FILE: hdl/dmcts_if.sv
interface dmcts_req_if;
    logic              valid;
    logic              ready;
    dmcts_pkg::cmd_t   cmd;
    dmcts_pkg::addr_t  addr;

    modport source (output valid, output cmd, output addr, input ready);
    modport sink   (input valid, input cmd, input addr, output ready);
endinterface

interface dmcts_rsp_if;
    logic              valid;
    logic              ready;
    logic              hit;
    dmcts_pkg::stall_t stall_cycles;
    dmcts_pkg::cnt_t   line_ref_count;
    dmcts_pkg::cnt_t   read_hits;
    dmcts_pkg::cnt_t   read_misses;
    dmcts_pkg::cnt_t   write_hits;
    dmcts_pkg::cnt_t   write_misses;
    dmcts_pkg::cnt_t   read_stall_total;
    dmcts_pkg::cnt_t   write_stall_total;
    dmcts_pkg::cnt_t   fetch_count;

    modport source (
        output valid, output hit, output stall_cycles, output line_ref_count,
        output read_hits, output read_misses, output write_hits, output write_misses,
        output read_stall_total, output write_stall_total, output fetch_count,
        input ready
    );
    modport sink (
        input valid, input hit, input stall_cycles, input line_ref_count,
        input read_hits, input read_misses, input write_hits, input write_misses,
        input read_stall_total, input write_stall_total, input fetch_count,
        output ready
    );
endinterface

FILE: hdl/direct_mapped_cache_tag_stats.sv
// channel  | dir | handshake     | beat
// req      | in  | valid / ready | cmd, addr
// rsp      | out | valid / ready | hit, stall, line ref count, statistics
// apb      | in  | psel/penable  | read miss penalty (0x0), write penalty (0x4)
//
// an access is a line store read, then a compare and, for reads, a write back
// one access at a time, set by the single-port line store read-modify-write
// after reset a clearing pass zeroes the line store, no req taken
// the response sits in an output register; the next req is taken while it is drained
// a stalled rsp holds the result and blocks new requests until taken
module direct_mapped_cache_tag_stats #(
    parameter int NUM_LINES  = 2048,
    parameter int LINE_BYTES = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dmcts_req_if.sink                             req,
    dmcts_rsp_if.source                           rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dmcts_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dmcts_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dmcts_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int TAG_W  = dmcts_pkg::ADDR_W - OFF_W - IDX_W;
    localparam int REFS_W = dmcts_pkg::CNT_W;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [REFS_W-1:0]   refs;
    } line_t;

    state_t                   state_reg;
    logic [IDX_W-1:0]         clr_cnt_reg;
    dmcts_pkg::cmd_t          cmd_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [TAG_W-1:0]         tag_reg;
    line_t                    rd_line_reg;

    dmcts_pkg::stall_t        rmp_reg;
    dmcts_pkg::stall_t        wp_reg;

    logic                     rsp_valid_reg;
    logic                     rsp_hit_reg;
    dmcts_pkg::stall_t        rsp_stall_reg;
    dmcts_pkg::cnt_t          rsp_refs_reg;
    dmcts_pkg::cnt_t          read_hits_reg;
    dmcts_pkg::cnt_t          read_misses_reg;
    dmcts_pkg::cnt_t          write_hits_reg;
    dmcts_pkg::cnt_t          write_misses_reg;
    dmcts_pkg::cnt_t          read_stall_reg;
    dmcts_pkg::cnt_t          write_stall_reg;
    dmcts_pkg::cnt_t          fetch_reg;

    line_t                    mem [NUM_LINES];

    logic                     req_fire;
    logic                     cfg_wr;
    logic                     is_read;
    logic                     hit;
    dmcts_pkg::stall_t        stall_next;
    dmcts_pkg::cnt_t          refs_next;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    line_t                    mem_wdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmp_reg <= dmcts_pkg::PENALTY_RESET;
            wp_reg  <= dmcts_pkg::PENALTY_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                dmcts_pkg::REG_READ_MISS_PENALTY: rmp_reg <= pwdata[dmcts_pkg::STALL_W-1:0];
                dmcts_pkg::REG_WRITE_PENALTY:     wp_reg  <= pwdata[dmcts_pkg::STALL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            dmcts_pkg::REG_READ_MISS_PENALTY:
                prdata = {{(dmcts_pkg::APB_DATA_W - dmcts_pkg::STALL_W){1'b0}}, rmp_reg};
            default:
                prdata = {{(dmcts_pkg::APB_DATA_W - dmcts_pkg::STALL_W){1'b0}}, wp_reg};
        endcase
    end

    // request side: one access in flight, output register must be free or being drained
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;

    // lookup and update of the indexed line
    always_comb
    begin
        is_read = cmd_reg inside {dmcts_pkg::CMD_FETCH, dmcts_pkg::CMD_LOAD};
        hit     = rd_line_reg.valid && (rd_line_reg.tag == tag_reg);
        if (!is_read)
        begin
            stall_next = wp_reg;
            refs_next  = rd_line_reg.refs;
        end
        else if (hit)
        begin
            stall_next = '0;
            refs_next  = dmcts_pkg::sat_inc(rd_line_reg.refs);
        end
        else
        begin
            stall_next = rmp_reg;
            refs_next  = dmcts_pkg::REFS_ON_FILL;
        end
    end

    // line store write: clearing pass, or read write-back
    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_LOOKUP) && is_read);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg;
        if (state_reg == ST_CLEAR)
            mem_wdata = '0;
        else
            mem_wdata = '{valid: 1'b1, tag: tag_reg, refs: refs_next};
    end

    // line store, registered read on accept; write-back lands before the next read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (req_fire)
        begin
            rd_line_reg <= mem[req.addr[OFF_W +: IDX_W]];
            cmd_reg     <= req.cmd;
            idx_reg     <= req.addr[OFF_W +: IDX_W];
            tag_reg     <= req.addr[OFF_W + IDX_W +: TAG_W];
        end
    end

    // sequencer, statistics and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            rsp_valid_reg    <= 1'b0;
            rsp_hit_reg      <= 1'b0;
            rsp_stall_reg    <= '0;
            rsp_refs_reg     <= '0;
            read_hits_reg    <= '0;
            read_misses_reg  <= '0;
            write_hits_reg   <= '0;
            write_misses_reg <= '0;
            read_stall_reg   <= '0;
            write_stall_reg  <= '0;
            fetch_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(NUM_LINES - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (req_fire)
                        state_reg <= ST_LOOKUP;
                end
                ST_LOOKUP:
                begin
                    state_reg     <= ST_IDLE;
                    rsp_valid_reg <= 1'b1;
                    rsp_hit_reg   <= hit;
                    rsp_stall_reg <= stall_next;
                    rsp_refs_reg  <= refs_next;
                    if (is_read)
                    begin
                        if (cmd_reg == dmcts_pkg::CMD_FETCH)
                            fetch_reg <= dmcts_pkg::sat_inc(fetch_reg);
                        if (hit)
                            read_hits_reg <= dmcts_pkg::sat_inc(read_hits_reg);
                        else
                            read_misses_reg <= dmcts_pkg::sat_inc(read_misses_reg);
                        read_stall_reg <= dmcts_pkg::sat_add(read_stall_reg, stall_next);
                    end
                    else
                    begin
                        if (hit)
                            write_hits_reg <= dmcts_pkg::sat_inc(write_hits_reg);
                        else
                            write_misses_reg <= dmcts_pkg::sat_inc(write_misses_reg);
                        write_stall_reg <= dmcts_pkg::sat_add(write_stall_reg, stall_next);
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // response beat; statistics only move when the response register is loaded
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.hit               = rsp_hit_reg;
    assign rsp.stall_cycles      = rsp_stall_reg;
    assign rsp.line_ref_count    = rsp_refs_reg;
    assign rsp.read_hits         = read_hits_reg;
    assign rsp.read_misses       = read_misses_reg;
    assign rsp.write_hits        = write_hits_reg;
    assign rsp.write_misses      = write_misses_reg;
    assign rsp.read_stall_total  = read_stall_reg;
    assign rsp.write_stall_total = write_stall_reg;
    assign rsp.fetch_count       = fetch_reg;

    // no access taken during the clearing pass
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    // an accepted access passes through lookup, then produces a response
    a_accept_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_LOOKUP) ##1 rsp_valid_reg)
        else $error("accepted access lost");

    // lookup never overwrites a pending response
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> !rsp_valid_reg)
        else $error("response register overrun");

    // saturating totals never go down
    a_read_stall_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (read_stall_reg >= $past(read_stall_reg)))
        else $error("read stall total decreased");

    a_write_stall_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (write_stall_reg >= $past(write_stall_reg)))
        else $error("write stall total decreased");

endmodule
